FILE: sv/gicuf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gicuf_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int CFG_W        = 7;
    localparam int COORD_W      = 6;
    localparam int COUNT_W      = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;
    localparam logic [CFG_W-1:0] GRID_RESET  = 7'd64;

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [1:0] STS_NEW   = 2'd0;
    localparam logic [1:0] STS_LAND  = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic                 cmd;
        logic [COORD_W-1:0]   cell_row;
        logic [COORD_W-1:0]   cell_col;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_W-1:0]   island_count;
        logic [1:0]           status;
    } t_out_beat;

    typedef enum logic [3:0] {
        OP_NONE, OP_TAKE, OP_SWEEP, OP_CHECK, OP_LREAD, OP_LCHK, OP_NB, OP_NBCHK,
        OP_FRD, OP_FCHK, OP_CRD, OP_CWR, OP_UNI, OP_UNI2
    } t_op;

    typedef enum logic [3:0] {
        S_RST_CLR, S_CMD_CLR, S_IDLE, S_CHECK, S_LREAD, S_LCHK, S_NB, S_NBCHK,
        S_FRD, S_FCHK, S_CRD, S_CWR, S_UNI, S_UNI2, S_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_cmd;
        logic in_range;
        logic land;
        logic nb_inb;
        logic k_done;
        logic p_root;
        logic x_root;
        logic which_b;
        logic roots_eq;
        logic clr_last;
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: sv/gicuf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gicuf_ctrl
    import gicuf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RST_CLR: if (i_sts.clr_last) n_state = S_IDLE;
            S_CMD_CLR: if (i_sts.clr_last) n_state = S_OUT;
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_sts.in_cmd == CMD_CLEAR) ? S_CMD_CLR : S_CHECK;
                end
            end
            S_CHECK:  n_state = i_sts.in_range ? S_LREAD : S_OUT;
            S_LREAD:  n_state = S_LCHK;
            S_LCHK:   n_state = i_sts.land ? S_OUT : S_NB;
            S_NB: begin
                priority if (i_sts.k_done) n_state = S_OUT;
                else if (i_sts.nb_inb)     n_state = S_NBCHK;
                else                       n_state = S_NB;
            end
            S_NBCHK:  n_state = i_sts.land ? S_FRD : S_NB;
            S_FRD:    n_state = S_FCHK;
            S_FCHK:   n_state = i_sts.p_root ? S_CRD : S_FRD;
            S_CRD: begin
                priority if (!i_sts.x_root) n_state = S_CWR;
                else if (i_sts.which_b)     n_state = S_UNI;
                else                        n_state = S_FRD;
            end
            S_CWR:    n_state = S_CRD;
            S_UNI:    n_state = i_sts.roots_eq ? S_NB : S_UNI2;
            S_UNI2:   n_state = S_NB;
            S_OUT:    if (i_ready) n_state = S_IDLE;
            default:  n_state = S_RST_CLR;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        o_cmd.op  = OP_NONE;
        unique case (r_state)
            S_RST_CLR, S_CMD_CLR: o_cmd.op = OP_SWEEP;
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_cmd.op = OP_TAKE;
            end
            S_CHECK:  o_cmd.op = OP_CHECK;
            S_LREAD:  o_cmd.op = OP_LREAD;
            S_LCHK:   o_cmd.op = OP_LCHK;
            S_NB:     o_cmd.op = OP_NB;
            S_NBCHK:  o_cmd.op = OP_NBCHK;
            S_FRD:    o_cmd.op = OP_FRD;
            S_FCHK:   o_cmd.op = OP_FCHK;
            S_CRD:    o_cmd.op = OP_CRD;
            S_CWR:    o_cmd.op = OP_CWR;
            S_UNI:    o_cmd.op = OP_UNI;
            S_UNI2:   o_cmd.op = OP_UNI2;
            S_OUT:    o_valid  = 1'b1;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/gicuf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module gicuf_dp
    import gicuf_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire t_in_beat         i_data,
    output t_out_beat             o_data,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int IDW   = $clog2(CELLS);
    localparam int SZW   = IDW + 1;
    localparam int MW    = 2 * CFG_W;

    logic [0:0]     land_mem [CELLS];
    logic [IDW-1:0] par_mem  [CELLS];
    logic [SZW-1:0] size_mem [CELLS];

    logic [CFG_W-1:0]   r_rows_cfg, r_cols_cfg;
    logic [COORD_W-1:0] r_row, r_col;
    logic [IDW-1:0]     r_id, r_nid, r_x, r_start, r_root, r_ra, r_rb, r_clr;
    logic [2:0]         r_k;
    logic               r_which;
    logic [COUNT_W-1:0] r_count;
    logic [1:0]         r_status;
    logic               r_land_q;
    logic [IDW-1:0]     r_par_q;
    logic [SZW-1:0]     r_sza_q, r_szb_q;

    logic [CFG_W-1:0] rows_eff, cols_eff;
    logic             in_range, nb_inb;
    logic [MW-1:0]    id_full;
    logic [IDW-1:0]   nb_id;
    logic [IDW-1:0]   land_raddr, land_waddr, par_waddr, par_wdata, size_waddr;
    logic             land_we, land_wdata, par_we, size_we;
    logic [SZW-1:0]   size_wdata;
    logic [SZW:0]     size_sum;
    logic [SZW-1:0]   size_new;
    logic             a_loses;

    assign rows_eff = ({4'd0, r_rows_cfg} > 11'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : r_rows_cfg;
    assign cols_eff = ({4'd0, r_cols_cfg} > 11'(MAX_COLS)) ? CFG_W'(MAX_COLS) : r_cols_cfg;
    assign in_range = ({1'b0, r_row} < rows_eff) && ({1'b0, r_col} < cols_eff);
    assign id_full  = MW'(r_row) * MW'(cols_eff) + MW'(r_col);

    always_comb begin
        nb_inb = 1'b0;
        nb_id  = r_id;
        unique case (r_k[1:0])
            DIR_UP: begin
                nb_inb = (r_row != '0);
                nb_id  = r_id - IDW'(cols_eff);
            end
            DIR_DOWN: begin
                nb_inb = ({1'b0, r_row} + 7'd1 < rows_eff);
                nb_id  = r_id + IDW'(cols_eff);
            end
            DIR_LEFT: begin
                nb_inb = (r_col != '0);
                nb_id  = r_id - IDW'(1);
            end
            DIR_RIGHT: begin
                nb_inb = ({1'b0, r_col} + 7'd1 < cols_eff);
                nb_id  = r_id + IDW'(1);
            end
            default: nb_inb = 1'b0;
        endcase
    end

    assign a_loses  = (r_sza_q <= r_szb_q);
    assign size_sum = {1'b0, r_sza_q} + {1'b0, r_szb_q};
    assign size_new = (size_sum > (SZW+1)'(CELLS)) ? SZW'(CELLS) : size_sum[SZW-1:0];

    always_comb begin
        land_raddr = (i_cmd.op == OP_LREAD) ? r_id : nb_id;
        land_we    = 1'b0;
        land_waddr = r_clr;
        land_wdata = 1'b0;
        par_we     = 1'b0;
        par_waddr  = r_id;
        par_wdata  = r_id;
        size_we    = 1'b0;
        size_waddr = r_id;
        size_wdata = SZW'(1);
        unique case (i_cmd.op)
            OP_SWEEP: land_we = 1'b1;
            OP_LCHK: begin
                if (!r_land_q) begin
                    land_we    = 1'b1;
                    land_waddr = r_id;
                    land_wdata = 1'b1;
                    par_we     = 1'b1;
                    size_we    = 1'b1;
                end
            end
            OP_CWR: begin
                par_we    = 1'b1;
                par_waddr = r_x;
                par_wdata = r_root;
            end
            OP_UNI2: begin
                par_we     = 1'b1;
                size_we    = 1'b1;
                size_wdata = size_new;
                par_waddr  = a_loses ? r_ra : r_rb;
                par_wdata  = a_loses ? r_rb : r_ra;
                size_waddr = a_loses ? r_rb : r_ra;
            end
            default: land_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (land_we) land_mem[land_waddr] <= land_wdata;
        if (par_we) par_mem[par_waddr] <= par_wdata;
        if (size_we) size_mem[size_waddr] <= size_wdata;
        r_land_q <= land_mem[land_raddr][0];
        r_par_q  <= par_mem[r_x];
        r_sza_q  <= size_mem[r_ra];
        r_szb_q  <= size_mem[r_rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= GRID_RESET;
            r_cols_cfg <= GRID_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_GRID_ROWS) r_rows_cfg <= i_cfg_data;
            if (i_cfg_idx == REG_GRID_COLS) r_cols_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_TAKE: begin
                    r_row <= i_data.cell_row;
                    r_col <= i_data.cell_col;
                    if (i_data.cmd == CMD_CLEAR) begin
                        r_count  <= '0;
                        r_status <= STS_NEW;
                        r_clr    <= '0;
                    end
                end
                OP_SWEEP: r_clr <= r_clr + IDW'(1);
                OP_CHECK: begin
                    r_id <= id_full[IDW-1:0];
                    if (!in_range) r_status <= STS_RANGE;
                end
                OP_LCHK: begin
                    r_k <= '0;
                    if (r_land_q) begin
                        r_status <= STS_LAND;
                    end else begin
                        r_status <= STS_NEW;
                        if (r_count < COUNT_MAX) r_count <= r_count + COUNT_W'(1);
                    end
                end
                OP_NB: begin
                    r_nid <= nb_id;
                    if (!r_k[2] && !nb_inb) r_k <= r_k + 3'd1;
                end
                OP_NBCHK: begin
                    if (!r_land_q) begin
                        r_k <= r_k + 3'd1;
                    end else begin
                        r_x     <= r_id;
                        r_start <= r_id;
                        r_which <= 1'b0;
                    end
                end
                OP_FCHK: begin
                    if (r_par_q == r_x) begin
                        r_root <= r_x;
                        r_x    <= r_start;
                    end else begin
                        r_x <= r_par_q;
                    end
                end
                OP_CRD: begin
                    if (r_x == r_root) begin
                        if (!r_which) begin
                            r_ra    <= r_root;
                            r_x     <= r_nid;
                            r_start <= r_nid;
                            r_which <= 1'b1;
                        end else begin
                            r_rb <= r_root;
                        end
                    end
                end
                OP_CWR: r_x <= r_par_q;
                OP_UNI: if (r_ra == r_rb) r_k <= r_k + 3'd1;
                OP_UNI2: begin
                    r_k <= r_k + 3'd1;
                    if (r_count != '0) r_count <= r_count - COUNT_W'(1);
                end
                default: r_k <= r_k;
            endcase
        end
    end

    assign o_sts.in_cmd   = i_data.cmd;
    assign o_sts.in_range = in_range;
    assign o_sts.land     = r_land_q;
    assign o_sts.nb_inb   = nb_inb;
    assign o_sts.k_done   = r_k[2];
    assign o_sts.p_root   = (r_par_q == r_x);
    assign o_sts.x_root   = (r_x == r_root);
    assign o_sts.which_b  = r_which;
    assign o_sts.roots_eq = (r_ra == r_rb);
    assign o_sts.clr_last = (r_clr == IDW'(CELLS - 1));

    assign o_data.island_count = r_count;
    assign o_data.status       = r_status;

endmodule
`default_nettype wire

FILE: sv/grid_island_counter_union_find_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   signals                          beat
// input     i_valid / o_ready / i_data       t_in_beat  {cmd, cell_row, cell_col}
// output    o_valid / i_ready / o_data       t_out_beat {island_count, status}
// config    i_cfg_we / i_cfg_idx / i_cfg_data  0 grid_rows, 1 grid_cols
// One beat in flight. An out-of-range beat goes straight to the result; an already
// land cell is read and reported; a new land cell checks each in-grid neighbor, and each
// land neighbor adds two finds (walk to the root, then compress the path, on one parent
// port), then a root compare and, on a merge, a union by size. Clear: one cell a cycle.
// Reset sweeps the whole land map before the first beat is taken.
// A result waits in the output stage until i_ready; no input taken meanwhile.
module grid_island_counter_union_find_top
    import gicuf_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_in_beat         i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_out_beat             o_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    gicuf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    gicuf_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (i_data),
        .o_data     (o_data),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts)
    );

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import gicuf_pkg::*;

    localparam int CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int LIMIT = 1500000;

    class island_tracker;
        bit          land[CELLS];
        int unsigned par[CELLS];
        int unsigned sz[CELLS];
        int unsigned islands;
        int unsigned rows_reg;
        int unsigned cols_reg;
        t_out_beat   want_q[$];
        int          errs;
        int          seen;
        int          merges;

        function new();
            rows_reg = 64;
            cols_reg = 64;
            islands = 0;
            errs = 0;
            seen = 0;
            merges = 0;
            foreach (land[i]) begin
                land[i] = 0;
                par[i] = 0;
                sz[i] = 0;
            end
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errs++;
        endfunction

        function void set_reg(logic idx, int unsigned val);
            if (idx == REG_GRID_ROWS) rows_reg = val & 7'h7f;
            else cols_reg = val & 7'h7f;
        endfunction

        function int unsigned find_root(int unsigned id);
            int unsigned r;
            int unsigned nx;
            int g;
            r = id;
            g = 0;
            while (par[r] != r && g < CELLS) begin
                r = par[r];
                g++;
            end
            g = 0;
            while (id != r && g < CELLS) begin
                nx = par[id];
                par[id] = r;
                id = nx;
                g++;
            end
            return r;
        endfunction

        function void take_beat(t_in_beat b);
            int dr[4];
            int dc[4];
            int rows;
            int cols;
            int r;
            int c;
            int ar;
            int ac;
            int unsigned id;
            int unsigned nid;
            int unsigned ra;
            int unsigned rb;
            int unsigned s;
            t_out_beat o;
            dr = '{-1, 1, 0, 0};
            dc = '{0, 0, -1, 1};
            rows = rows_reg > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows_reg;
            cols = cols_reg > DEF_MAX_COLS ? DEF_MAX_COLS : cols_reg;
            r = b.cell_row;
            c = b.cell_col;
            if (b.cmd == CMD_CLEAR) begin
                foreach (land[i]) land[i] = 0;
                islands = 0;
                o.status = STS_NEW;
            end else if (r >= rows || c >= cols) begin
                o.status = STS_RANGE;
            end else begin
                id = r * cols + c;
                if (land[id]) begin
                    o.status = STS_LAND;
                end else begin
                    o.status = STS_NEW;
                    land[id] = 1;
                    par[id] = id;
                    sz[id] = 1;
                    if (islands < COUNT_MAX) islands++;
                    for (int k = 0; k < 4; k++) begin
                        ar = r + dr[k];
                        ac = c + dc[k];
                        if (ar < 0 || ar >= rows || ac < 0 || ac >= cols) continue;
                        nid = ar * cols + ac;
                        if (!land[nid]) continue;
                        ra = find_root(id);
                        rb = find_root(nid);
                        if (ra != rb) begin
                            if (sz[ra] <= sz[rb]) begin
                                par[ra] = rb;
                                s = sz[rb] + sz[ra];
                                sz[rb] = s > CELLS ? CELLS : s;
                            end else begin
                                par[rb] = ra;
                                s = sz[ra] + sz[rb];
                                sz[ra] = s > CELLS ? CELLS : s;
                            end
                            merges++;
                            if (islands > 0) islands--;
                        end
                    end
                end
            end
            o.island_count = islands[COUNT_W-1:0];
            want_q = {want_q, o};
        endfunction

        function void match_result(t_out_beat got);
            t_out_beat w;
            seen++;
            if (want_q.size() == 0) begin
                report($sformatf("unexpected result beat %h", got));
                return;
            end
            w = want_q.pop_front();
            if (got.island_count !== w.island_count)
                report($sformatf("beat %0d island_count %0d, want %0d",
                                 seen, got.island_count, w.island_count));
            if (got.status !== w.status)
                report($sformatf("beat %0d status %0d, want %0d",
                                 seen, got.status, w.status));
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_valid;
    logic             o_ready;
    t_in_beat         i_data;
    logic             o_valid;
    logic             i_ready;
    t_out_beat        o_data;

    island_tracker tracker;
    int idle_pct;
    int stall_pct;
    int hold_req;
    int cycles;
    int n_items;
    int n_clears;

    grid_island_counter_union_find_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // result side, with a long hold-off on request
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) tracker.match_result(o_data);
            if (hold_req > 0) begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_beat(logic cmd, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        t_in_beat b;
        int gap;
        b.cmd = cmd;
        b.cell_row = r;
        b.cell_col = c;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.take_beat(b);
        n_items++;
        if (cmd == CMD_CLEAR) n_clears++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.want_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_grid(int unsigned rows, int unsigned cols);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_GRID_ROWS;
        i_cfg_data <= rows[CFG_W-1:0];
        @(posedge i_clk);
        tracker.set_reg(REG_GRID_ROWS, rows);
        i_cfg_idx <= REG_GRID_COLS;
        i_cfg_data <= cols[CFG_W-1:0];
        @(posedge i_clk);
        tracker.set_reg(REG_GRID_COLS, cols);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_run(int count, bit clear_first);
        int rows;
        int cols;
        int pick;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        rows = tracker.rows_reg > 64 ? 64 : tracker.rows_reg;
        cols = tracker.cols_reg > 64 ? 64 : tracker.cols_reg;
        if (clear_first) send_beat(CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(999);
            if (pick < 12) begin
                send_beat(CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
            end else begin
                if (pick < 160 || rows == 0 || cols == 0) begin
                    r = COORD_W'($urandom);
                    c = COORD_W'($urandom);
                end else begin
                    r = COORD_W'($urandom_range(rows - 1));
                    c = COORD_W'($urandom_range(cols - 1));
                end
                send_beat(CMD_ADD, r, c);
            end
        end
    endtask

    initial begin
        int grids[10][2];
        tracker = new();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_GRID_ROWS;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_ready <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        n_items = 0;
        n_clears = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners of the full grid, repeat add, a merge, clear
        send_beat(CMD_ADD, 0, 0);
        send_beat(CMD_ADD, 63, 63);
        send_beat(CMD_ADD, 0, 63);
        send_beat(CMD_ADD, 63, 0);
        send_beat(CMD_ADD, 0, 0);
        send_beat(CMD_ADD, 0, 1);
        send_beat(CMD_ADD, 1, 63);
        send_beat(CMD_CLEAR, 63, 63);
        // small grid: out of range on each axis, four-way merge
        write_grid(3, 5);
        send_beat(CMD_ADD, 3, 0);
        send_beat(CMD_ADD, 0, 5);
        send_beat(CMD_ADD, 63, 63);
        send_beat(CMD_ADD, 0, 1);
        send_beat(CMD_ADD, 1, 0);
        send_beat(CMD_ADD, 1, 2);
        send_beat(CMD_ADD, 2, 1);
        send_beat(CMD_ADD, 1, 1);
        send_beat(CMD_ADD, 1, 1);
        // stride change with land present
        write_grid(5, 3);
        send_beat(CMD_ADD, 2, 2);
        send_beat(CMD_ADD, 4, 0);
        // zero size, then oversized
        write_grid(0, 0);
        send_beat(CMD_ADD, 0, 0);
        write_grid(127, 127);
        send_beat(CMD_ADD, 63, 62);
        send_beat(CMD_ADD, 62, 63);
        send_beat(CMD_ADD, 63, 63);

        grids = '{'{8, 8}, '{1, 64}, '{64, 1}, '{5, 7}, '{127, 100},
                  '{2, 2}, '{16, 16}, '{64, 64}, '{0, 9}, '{12, 3}};
        for (int p = 0; p < 10; p++) begin
            write_grid(grids[p][0], grids[p][1]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            if (p == 3) hold_req = 3000;
            random_run(p == 7 ? 200 : 95, p % 3 == 0);
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (tracker.want_q.size() != 0)
            tracker.report($sformatf("%0d results never came", tracker.want_q.size()));
        $display("covered %0d beats (%0d clears, %0d merges) over 10 grid shapes,",
                 n_items, n_clears, tracker.merges);
        $display("with sender gaps, receiver stalls and one long output hold-off");
        if (tracker.errs == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
